FILE: rtl/core/tcs_pkg.sv
// Shared constants, command codes and command type of the text terminal.
package tcs_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	localparam logic [1:0] FUNC_PUT = 2'd0;
	localparam logic [1:0] FUNC_SET = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CHAR,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_SET,
		OP_READ
	} tcs_op_t;

	typedef struct packed {
		tcs_op_t op;
		logic [7:0] ch;
		logic [7:0] at;
	} tcs_cmd_t;

endpackage

FILE: rtl/core/tcs_front.sv
// Front end: input acceptance, default attribute register and command classification.
module tcs_front
	import tcs_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int COL_W = $clog2(COLUMNS),
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [7:0] char_code,
	input  logic [7:0] attr,
	input  logic use_default_attr,
	input  logic [COL_W-1:0] cell_col,
	input  logic [ROW_W-1:0] cell_row,
	input  logic fifo_full,
	input  logic init_busy,
	output logic push,
	output tcs_cmd_t push_cmd
);

	logic [7:0] default_attr_q;
	logic in_screen;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			default_attr_q <= cfg_data;
		end
	end

	assign in_ready = !fifo_full && !init_busy;
	assign push = in_valid && in_ready;

	assign in_screen = ({1'b0, cell_col} < (COL_W + 1)'(COLUMNS)) &&
		({1'b0, cell_row} < (ROW_W + 1)'(ROWS));

	always_comb begin
		push_cmd.ch = char_code;
		push_cmd.at = use_default_attr ? default_attr_q : attr;
		unique case (func)
			FUNC_PUT: begin
				if (char_code == CH_NEWLINE) begin
					push_cmd.op = OP_NEWLINE;
				end else if (char_code == CH_BACKSPACE) begin
					push_cmd.op = OP_BACKSPACE;
				end else begin
					push_cmd.op = OP_CHAR;
				end
			end
			FUNC_SET: push_cmd.op = in_screen ? OP_SET : OP_NOP;
			FUNC_READ: push_cmd.op = in_screen ? OP_READ : OP_NOP;
			default: push_cmd.op = OP_NOP;
		endcase
	end

endmodule

FILE: rtl/core/tcs_cmd_fifo.sv
// Short command queue between the front end and the back end.
module tcs_cmd_fifo
	import tcs_pkg::*;
#(
	parameter int COL_W = 7,
	parameter int ROW_W = 5,
	parameter int DEPTH = FIFO_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tcs_cmd_t push_cmd,
	input  logic [COL_W-1:0] push_col,
	input  logic [ROW_W-1:0] push_row,
	output logic full,
	output logic head_valid,
	output tcs_cmd_t head_cmd,
	output logic [COL_W-1:0] head_col,
	output logic [ROW_W-1:0] head_row,
	input  logic pop
);

	tcs_cmd_t cmd_q [DEPTH];
	logic [COL_W-1:0] col_q [DEPTH];
	logic [ROW_W-1:0] row_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = cmd_q[rd_ptr_q];
	assign head_col = col_q[rd_ptr_q];
	assign head_row = row_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			col_q[wr_ptr_q] <= push_col;
			row_q[wr_ptr_q] <= push_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/tcs_back.sv
// Back end: cursor, circular screen memory, scroll and clearing sweeps, result register.
module tcs_back
	import tcs_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int COL_W = $clog2(COLUMNS),
	localparam int ROW_W = $clog2(ROWS),
	localparam int CELLS = ROWS * COLUMNS,
	localparam int ADDR_W = $clog2(CELLS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  tcs_cmd_t head_cmd,
	input  logic [COL_W-1:0] head_col,
	input  logic [ROW_W-1:0] head_row,
	output logic pop,
	output logic init_busy,
	output logic out_valid,
	input  logic out_ready,
	output logic [COL_W-1:0] cursor_col,
	output logic [ROW_W-1:0] cursor_row,
	output logic scrolled,
	output logic [7:0] read_char,
	output logic [7:0] read_attr
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] top_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] clr_last_q;
	logic out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic out_scrolled_q;
	logic [7:0] out_char_q;
	logic [7:0] out_attr_q;

	logic [15:0] mem [CELLS];
	logic [15:0] rd_data_q;

	logic take;
	logic clearing;
	logic addressed;
	logic [COL_W-1:0] sel_col;
	logic [ROW_W-1:0] sel_row;
	logic [ROW_W:0] row_sum;
	logic [ROW_W-1:0] phys_row;
	logic [ADDR_W-1:0] cell_addr;
	logic [ADDR_W-1:0] top_base;
	logic [COL_W-1:0] next_col;
	logic [ROW_W-1:0] next_row;
	logic do_scroll;
	logic mem_we;
	logic mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0] mem_wdata;

	assign take = (state_q == ST_IDLE) && head_valid && !out_valid_q;
	assign pop = take;
	assign init_busy = (state_q == ST_INIT);
	assign clearing = (state_q == ST_INIT) || (state_q == ST_CLEAR);

	assign addressed = (head_cmd.op == OP_SET) || (head_cmd.op == OP_READ);
	assign sel_col = addressed ? head_col : cur_col_q;
	assign sel_row = addressed ? head_row : cur_row_q;
	assign row_sum = {1'b0, sel_row} + {1'b0, top_q};
	assign phys_row = (row_sum >= (ROW_W + 1)'(ROWS)) ?
		ROW_W'(row_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(row_sum);
	assign cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);
	assign top_base = ADDR_W'(top_q) * ADDR_W'(COLUMNS);

	always_comb begin
		next_col = cur_col_q;
		next_row = cur_row_q;
		do_scroll = 1'b0;
		case (head_cmd.op)
			OP_NEWLINE: begin
				next_col = '0;
				if (cur_row_q == ROW_W'(ROWS - 1)) begin
					do_scroll = 1'b1;
				end else begin
					next_row = cur_row_q + 1'b1;
				end
			end
			OP_BACKSPACE: begin
				if (cur_col_q != '0) begin
					next_col = cur_col_q - 1'b1;
				end else if (cur_row_q != '0) begin
					next_col = COL_W'(COLUMNS - 1);
					next_row = cur_row_q - 1'b1;
				end
			end
			OP_CHAR: begin
				if (cur_col_q == COL_W'(COLUMNS - 1)) begin
					next_col = '0;
					if (cur_row_q == ROW_W'(ROWS - 1)) begin
						do_scroll = 1'b1;
					end else begin
						next_row = cur_row_q + 1'b1;
					end
				end else begin
					next_col = cur_col_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we = clearing ||
		(take && ((head_cmd.op == OP_CHAR) || (head_cmd.op == OP_SET)));
	assign mem_re = take && (head_cmd.op == OP_READ);
	assign mem_addr = clearing ? clr_addr_q : cell_addr;
	assign mem_wdata = clearing ? 16'h0000 : {head_cmd.at, head_cmd.ch};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q <= '0;
			clr_addr_q <= '0;
			clr_last_q <= ADDR_W'(CELLS - 1);
			out_valid_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_scrolled_q <= 1'b0;
			out_char_q <= '0;
			out_attr_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == clr_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						cur_col_q <= next_col;
						cur_row_q <= next_row;
						out_col_q <= next_col;
						out_row_q <= next_row;
						out_scrolled_q <= do_scroll;
						out_char_q <= '0;
						out_attr_q <= '0;
						if (head_cmd.op == OP_READ) begin
							state_q <= ST_READ;
						end else begin
							out_valid_q <= 1'b1;
						end
						if (do_scroll) begin
							top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
							clr_addr_q <= top_base;
							clr_last_q <= top_base + ADDR_W'(COLUMNS - 1);
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_READ: begin
					out_char_q <= rd_data_q[7:0];
					out_attr_q <= rd_data_q[15:8];
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign scrolled = out_scrolled_q;
	assign read_char = out_char_q;
	assign read_attr = out_attr_q;

endmodule

FILE: rtl/core/text_terminal_cursor_scroll.sv
// Top level of the character-cell text terminal with cursor and scroll.
// After reset the block sweeps the screen memory to zero, one cell per cycle; in_ready
// stays low during this sweep, while configuration writes are taken at any time. Items
// then pass through a two-entry command queue to the back end, which handles one item at
// a time and takes the next one only once the result of the last has been taken: a read
// item passes through a read state because of the registered memory read, and an item
// that scrolls is followed by a sweep that clears the new bottom row. Scrolling moves
// no cells: the screen is a ring of rows whose top row index advances.
module text_terminal_cursor_scroll
	import tcs_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int COL_W = $clog2(COLUMNS),
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [7:0] char_code,
	input  logic [7:0] attr,
	input  logic use_default_attr,
	input  logic [COL_W-1:0] cell_col,
	input  logic [ROW_W-1:0] cell_row,
	output logic out_valid,
	input  logic out_ready,
	output logic [COL_W-1:0] cursor_col,
	output logic [ROW_W-1:0] cursor_row,
	output logic scrolled,
	output logic [7:0] read_char,
	output logic [7:0] read_attr
);

	logic push;
	tcs_cmd_t push_cmd;
	logic fifo_full;
	logic init_busy;
	logic head_valid;
	tcs_cmd_t head_cmd;
	logic [COL_W-1:0] head_col;
	logic [ROW_W-1:0] head_row;
	logic pop;

	tcs_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.char_code(char_code),
		.attr(attr),
		.use_default_attr(use_default_attr),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.fifo_full(fifo_full),
		.init_busy(init_busy),
		.push(push),
		.push_cmd(push_cmd)
	);

	tcs_cmd_fifo #(
		.COL_W(COL_W),
		.ROW_W(ROW_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.push_col(cell_col),
		.push_row(cell_row),
		.full(fifo_full),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.head_col(head_col),
		.head_row(head_row),
		.pop(pop)
	);

	tcs_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.head_col(head_col),
		.head_row(head_row),
		.pop(pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.scrolled(scrolled),
		.read_char(read_char),
		.read_attr(read_attr)
	);

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the text terminal cursor, scroll and cell access block.
`timescale 1ns / 100ps

module tb_top;
	import tcs_pkg::*;

	localparam int NCOL = COLUMNS_DEF;
	localparam int NROW = ROWS_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 2 * NCOL + 20;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] ch;
		logic [7:0] at;
		logic use_def;
		logic [6:0] col;
		logic [4:0] row;
	} term_req_t;

	typedef struct packed {
		logic [6:0] col;
		logic [4:0] row;
		logic scrolled;
		logic [7:0] rch;
		logic [7:0] rat;
	} term_resp_t;

	class term_scoreboard;
		logic [15:0] cells [NROW * NCOL];
		int cur_col;
		int cur_row;
		logic [7:0] dflt_attr;
		term_resp_t pending_results [$];
		int errors;

		function new();
			foreach (cells[i]) cells[i] = '0;
			cur_col = 0;
			cur_row = 0;
			dflt_attr = ATTR_RESET;
			errors = 0;
		endfunction

		function void set_default_attr(logic [7:0] v);
			dflt_attr = v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function void note_request(term_req_t rq);
			term_resp_t rs;
			logic [7:0] eff;
			logic [15:0] v;
			bit in_screen;
			rs = '0;
			eff = rq.use_def ? dflt_attr : rq.at;
			in_screen = (rq.col < NCOL) && (rq.row < NROW);
			case (rq.func)
				FUNC_PUT: begin
					if (rq.ch == CH_NEWLINE) begin
						cur_col = 0;
						cur_row++;
					end else if (rq.ch == CH_BACKSPACE) begin
						if (cur_col > 0) begin
							cur_col--;
						end else if (cur_row > 0) begin
							cur_col = NCOL - 1;
							cur_row--;
						end
					end else begin
						cells[cur_row * NCOL + cur_col] = {eff, rq.ch};
						cur_col++;
					end
					if (cur_col >= NCOL) begin
						cur_col = 0;
						cur_row++;
					end
					if (cur_row >= NROW) begin
						cur_row = NROW - 1;
						for (int i = 0; i < (NROW - 1) * NCOL; i++)
							cells[i] = cells[i + NCOL];
						for (int i = (NROW - 1) * NCOL; i < NROW * NCOL; i++)
							cells[i] = '0;
						rs.scrolled = 1'b1;
					end
				end
				FUNC_SET: begin
					if (in_screen)
						cells[rq.row * NCOL + rq.col] = {eff, rq.ch};
				end
				FUNC_READ: begin
					if (in_screen) begin
						v = cells[rq.row * NCOL + rq.col];
						rs.rch = v[7:0];
						rs.rat = v[15:8];
					end
				end
				default: ;
			endcase
			rs.col = cur_col[6:0];
			rs.row = cur_row[4:0];
			pending_results.push_back(rs);
		endfunction

		task check_response(term_resp_t got);
			term_resp_t want;
			if (pending_results.size() == 0) begin
				report("result transaction with no item outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got.col != want.col)
					report($sformatf("cursor_col %0d, expected %0d", got.col, want.col));
				if (got.row != want.row)
					report($sformatf("cursor_row %0d, expected %0d", got.row, want.row));
				if (got.scrolled != want.scrolled)
					report($sformatf("scrolled %0b, expected %0b", got.scrolled, want.scrolled));
				if (got.rch != want.rch)
					report($sformatf("read_char %h, expected %h", got.rch, want.rch));
				if (got.rat != want.rat)
					report($sformatf("read_attr %h, expected %h", got.rat, want.rat));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [7:0] char_code;
	logic [7:0] attr;
	logic use_default_attr;
	logic [6:0] cell_col;
	logic [4:0] cell_row;
	logic out_valid;
	logic out_ready;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic scrolled;
	logic [7:0] read_char;
	logic [7:0] read_attr;

	term_scoreboard sb;
	bit quiet;
	bit long_hold;
	int cycle_count;

	text_terminal_cursor_scroll #(
		.COLUMNS(NCOL),
		.ROWS(NROW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.char_code(char_code),
		.attr(attr),
		.use_default_attr(use_default_attr),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.scrolled(scrolled),
		.read_char(read_char),
		.read_attr(read_attr)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (out_valid && out_ready)
				sb.check_response({cursor_col, cursor_row, scrolled, read_char, read_attr});
			if (cfg_valid && cfg_ready)
				sb.set_default_attr(cfg_data);
			if (in_valid && in_ready)
				sb.note_request({func, char_code, attr, use_default_attr, cell_col, cell_row});
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic term_req_t make_req(logic [1:0] f, logic [7:0] ch, logic [7:0] at,
			logic ud, logic [6:0] col, logic [4:0] row);
		term_req_t rq;
		rq.func = f;
		rq.ch = ch;
		rq.at = at;
		rq.use_def = ud;
		rq.col = col;
		rq.row = row;
		return rq;
	endfunction

	function automatic term_req_t random_request();
		term_req_t rq;
		int r;
		rq.ch = 8'($urandom_range(0, 255));
		rq.at = 8'($urandom_range(0, 255));
		rq.use_def = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 85) begin
			rq.col = 7'($urandom_range(0, NCOL - 1));
			rq.row = 5'($urandom_range(0, NROW - 1));
		end else begin
			rq.col = 7'($urandom_range(0, 127));
			rq.row = 5'($urandom_range(0, 31));
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			rq.func = FUNC_PUT;
		end else if (r < 63) begin
			rq.func = FUNC_PUT;
			rq.ch = CH_NEWLINE;
		end else if (r < 70) begin
			rq.func = FUNC_PUT;
			rq.ch = CH_BACKSPACE;
		end else if (r < 80) begin
			rq.func = FUNC_SET;
		end else if (r < 97) begin
			rq.func = FUNC_READ;
			if ($urandom_range(0, 1) == 1) begin
				rq.row = 5'((sb.cur_row > 0 && $urandom_range(0, 1) == 1) ?
					sb.cur_row - 1 : sb.cur_row);
				rq.col = 7'($urandom_range(0, NCOL - 1));
			end
		end else begin
			rq.func = FUNC_UNUSED;
		end
		return rq;
	endfunction

	task automatic offer(term_req_t rq, int gap);
		in_valid <= 1'b1;
		func <= rq.func;
		char_code <= rq.ch;
		attr <= rq.at;
		use_default_attr <= rq.use_def;
		cell_col <= rq.col;
		cell_row <= rq.row;
		do @(posedge clk); while (!in_ready);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	task automatic write_default_attr(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic reconfigure(logic [7:0] v);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		write_default_attr(v);
	endtask

	task automatic run_random(int count, int hold_at, int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				long_hold = 1'b1;
			if (i == pause_at) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			offer(random_request(), pick_gap());
		end
	endtask

	initial begin
		term_req_t directed [$];
		sb = new();
		quiet = 1'b0;
		long_hold = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_PUT;
		char_code = '0;
		attr = '0;
		use_default_attr = 1'b0;
		cell_col = '0;
		cell_row = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 8'h33, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_PUT, 8'h41, 8'h00, 1'b0, 7'd127, 5'd31));
		directed.push_back(make_req(FUNC_PUT, 8'hFF, 8'hFF, 1'b1, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_PUT, 8'h00, 8'h55, 1'b0, 7'd5, 5'd5));
		directed.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 8'h00, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'hFF, 8'hFF, 1'b1, 7'd1, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd2, 5'd0));
		directed.push_back(make_req(FUNC_PUT, CH_NEWLINE, 8'hAA, 1'b1, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_PUT, CH_BACKSPACE, 8'h00, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_PUT, 8'h5A, 8'hC3, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd0));
		directed.push_back(make_req(FUNC_SET, 8'hFF, 8'hFF, 1'b0, 7'd79, 5'd24));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd24));
		directed.push_back(make_req(FUNC_SET, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		directed.push_back(make_req(FUNC_SET, 8'h77, 8'h88, 1'b0, 7'd127, 5'd31));
		directed.push_back(make_req(FUNC_SET, 8'h66, 8'h99, 1'b0, 7'd80, 5'd24));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd80, 5'd0));
		directed.push_back(make_req(FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd25));
		directed.push_back(make_req(FUNC_UNUSED, 8'hA5, 8'h5A, 1'b1, 7'd3, 5'd3));
		directed.push_back(make_req(FUNC_UNUSED, CH_NEWLINE, 8'h00, 1'b0, 7'd0, 5'd0));
		foreach (directed[i])
			offer(directed[i], pick_gap());

		reconfigure(8'h00);
		quiet = 1'b1;
		run_random(150, -1, -1);
		quiet = 1'b0;

		reconfigure(8'hFF);
		run_random(170, 60, -1);

		reconfigure(8'($urandom_range(1, 254)));
		run_random(170, -1, 85);

		reconfigure(8'hA5);
		run_random(140, -1, -1);

		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_front.sv
rtl/core/tcs_cmd_fifo.sv
rtl/core/tcs_back.sv
rtl/core/text_terminal_cursor_scroll.sv
bench/tb_top.sv
